@@ sv/imm_pkg.sv @@
// ----------------------------------------------------------------------------
// imm_pkg
// Shared types, constants and helpers for the integer matrix multiply core.
// ----------------------------------------------------------------------------
package imm_pkg;

  // Matrix geometry
  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = 4;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  // Input item modes
  typedef enum logic [1:0] {
    MODE_LOAD_X = 2'd0,
    MODE_LOAD_Y = 2'd1,
    MODE_START  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Register indexes (word address)
  typedef enum logic [1:0] {
    REG_ROWS  = 2'd0,
    REG_INNER = 2'd1,
    REG_COLS  = 2'd2,
    REG_NONE  = 2'd3
  } reg_idx_t;

  // Control into the shared MAC
  typedef struct packed {
    logic valid;  // operand pair present this cycle
    logic clear;  // zero the accumulator
  } mac_ctl_t;

  // Highest index for a dimension register: zero acts as one, above MAX_DIM clamps
  function automatic logic [IDX_W-1:0] last_idx(input logic [DIM_W-1:0] dim);
    logic [IDX_W-1:0] res;
    if (dim == '0) begin
      res = '0;
    end else if (dim > DIM_W'(MAX_DIM)) begin
      res = IDX_W'(MAX_DIM - 1);
    end else begin
      res = IDX_W'(dim - DIM_W'(1));
    end
    return res;
  endfunction

endpackage

@@ sv/imm_ram.sv @@
// ----------------------------------------------------------------------------
// imm_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module imm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ sv/imm_mac.sv @@
// ----------------------------------------------------------------------------
// imm_mac
// Shared multiply-accumulate unit: registered product, then wrapping add.
// ----------------------------------------------------------------------------
module imm_mac
  import imm_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  mac_ctl_t          ctl,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] acc,
  output logic              busy
);

  logic [2*DATA_W-1:0] prod_full;
  logic [DATA_W-1:0]   prod;
  logic                prod_valid;

  assign prod_full = a * b;
  assign busy      = prod_valid;

  // Product stage, low word only since the sum wraps modulo 2^32
  always_ff @(posedge clk) begin
    prod <= prod_full[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else begin
      prod_valid <= ctl.valid;
    end
  end

  // Accumulate stage
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc <= '0;
    end else if (prod_valid) begin
      acc <= acc + prod;
    end
  end

endmodule

@@ sv/integer_matrix_multiply_core.sv @@
// ----------------------------------------------------------------------------
// integer_matrix_multiply_core
// Load items are accepted one per cycle into the X and Y stores while the core
// is idle; a start item runs the multiply, and no new items are taken until done.
// Each result element reads its operand pairs through the shared multiplier
// and RAM read ports, then drains the pipeline and makes one output transfer.
// Synchronous reset clears control and sets every dimension to 8; the stores
// are not cleared and hold undefined data until written.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_core
  import imm_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  // input items
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          mode,
  input  logic [IDX_W-1:0]    row_index,
  input  logic [IDX_W-1:0]    col_index,
  input  logic signed [DATA_W-1:0] element,
  // result items
  output logic                out_valid,
  input  logic                out_ready,
  output logic [IDX_W-1:0]    out_row,
  output logic [IDX_W-1:0]    out_col,
  output logic signed [DATA_W-1:0] out_value,
  output logic                last
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_DRAIN = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t            state;
  state_t            state_next;

  logic [DIM_W-1:0]  rows;
  logic [DIM_W-1:0]  inner_size;
  logic [DIM_W-1:0]  cols;

  logic [IDX_W-1:0]  row_cnt;
  logic [IDX_W-1:0]  col_cnt;
  logic [IDX_W-1:0]  k_cnt;
  logic [IDX_W-1:0]  row_last;
  logic [IDX_W-1:0]  col_last;
  logic [IDX_W-1:0]  k_last;

  logic              rd_valid;
  logic              in_xfer;
  logic              cfg_wr;
  reg_idx_t          cfg_idx;
  mode_t             in_mode;

  logic              x_we;
  logic              y_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] x_raddr;
  logic [ADDR_W-1:0] y_raddr;
  logic [DATA_W-1:0] x_rdata;
  logic [DATA_W-1:0] y_rdata;

  mac_ctl_t          mac_ctl;
  logic [DATA_W-1:0] mac_acc;
  logic              mac_busy;
  logic              final_elem;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows       <= DIM_W'(MAX_DIM);
      inner_size <= DIM_W'(MAX_DIM);
      cols       <= DIM_W'(MAX_DIM);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ROWS:  rows       <= pwdata[DIM_W-1:0];
        REG_INNER: inner_size <= pwdata[DIM_W-1:0];
        REG_COLS:  cols       <= pwdata[DIM_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ROWS:  prdata = {{(PDATA_W-DIM_W){1'b0}}, rows};
      REG_INNER: prdata = {{(PDATA_W-DIM_W){1'b0}}, inner_size};
      REG_COLS:  prdata = {{(PDATA_W-DIM_W){1'b0}}, cols};
      default:   prdata = '0;
    endcase
  end

  assign row_last = last_idx(rows);
  assign k_last   = last_idx(inner_size);
  assign col_last = last_idx(cols);

  // Input transfers and store writes
  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign in_mode  = mode_t'(mode);
  assign x_we     = in_xfer && (in_mode == MODE_LOAD_X);
  assign y_we     = in_xfer && (in_mode == MODE_LOAD_Y);
  assign wr_addr  = {row_index, col_index};

  // Operand addresses: X[i][k] and Y[k][j]
  assign x_raddr = {row_cnt, k_cnt};
  assign y_raddr = {k_cnt, col_cnt};

  imm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (x_we),
    .waddr (wr_addr),
    .wdata (element),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  imm_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (y_we),
    .waddr (wr_addr),
    .wdata (element),
    .raddr (y_raddr),
    .rdata (y_rdata)
  );

  // Read data valid in the cycle after an issue
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= (state == S_RUN);
    end
  end

  assign mac_ctl.valid = rd_valid;
  assign mac_ctl.clear = (state == S_RUN) && (k_cnt == '0);

  imm_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .a    (x_rdata),
    .b    (y_rdata),
    .acc  (mac_acc),
    .busy (mac_busy)
  );

  assign final_elem = (row_cnt == row_last) && (col_cnt == col_last);

  // Sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && (in_mode == MODE_START)) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (k_cnt == k_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_valid && !mac_busy) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          state_next = final_elem ? S_IDLE : S_RUN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_cnt <= '0;
      col_cnt <= '0;
      k_cnt   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          row_cnt <= '0;
          col_cnt <= '0;
          k_cnt   <= '0;
        end
        S_RUN: begin
          if (k_cnt != k_last) begin
            k_cnt <= k_cnt + IDX_W'(1);
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            k_cnt <= '0;
            if (col_cnt == col_last) begin
              col_cnt <= '0;
              row_cnt <= row_cnt + IDX_W'(1);
            end else begin
              col_cnt <= col_cnt + IDX_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DRAIN) && !rd_valid && !mac_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DRAIN) && !rd_valid && !mac_busy) begin
      out_row   <= row_cnt;
      out_col   <= col_cnt;
      out_value <= mac_acc;
      last      <= final_elem;
    end
  end

endmodule
